// ===== rtl/dva_pkg.sv =====
`timescale 1ns / 1ps

package dva_pkg;

    localparam int CHANNELS  = 4;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SAMPLES   = 7;
    localparam int LEN_W     = 16;
    localparam int PROD_W    = 2 * LEN_W;
    localparam int OP_W      = 2;
    localparam int NOTE_W    = 7;
    localparam int VEL_W     = 7;
    localparam int ACT_W     = 2;
    localparam int CHAN_W    = 2;
    localparam int SMP_W     = 3;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_ALL_OFF  = 2'd2,
        OP_TICK     = 2'd3
    } op_t;

    localparam logic [ACT_W-1:0] ACT_NONE     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_START    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_STOP     = 2'd2;
    localparam logic [ACT_W-1:0] ACT_STOP_ALL = 2'd3;

    localparam logic [SMP_W-1:0] SMP_NULL       = 3'd0;
    localparam logic [SMP_W-1:0] SMP_KICK       = 3'd1;
    localparam logic [SMP_W-1:0] SMP_SNARE      = 3'd2;
    localparam logic [SMP_W-1:0] SMP_SNARE_ALT  = 3'd3;
    localparam logic [SMP_W-1:0] SMP_HAT_CLOSED = 3'd4;
    localparam logic [SMP_W-1:0] SMP_HAT_OPEN   = 3'd5;
    localparam logic [SMP_W-1:0] SMP_COWBELL    = 3'd6;
    localparam logic [SMP_W-1:0] SMP_CRASH      = 3'd7;

    localparam logic [NOTE_W-1:0] NOTE_KICK       = 7'd36;
    localparam logic [NOTE_W-1:0] NOTE_SNARE      = 7'd38;
    localparam logic [NOTE_W-1:0] NOTE_SNARE_ALT  = 7'd40;
    localparam logic [NOTE_W-1:0] NOTE_HAT_CLOSED = 7'd42;
    localparam logic [NOTE_W-1:0] NOTE_HAT_OPEN   = 7'd46;
    localparam logic [NOTE_W-1:0] NOTE_CRASH      = 7'd49;
    localparam logic [NOTE_W-1:0] NOTE_COWBELL    = 7'd56;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ON_SCORE,
        ST_ON_MULA,
        ST_ON_MULB,
        ST_ON_COMMIT,
        ST_OFF_SCAN,
        ST_TICK_SCAN,
        ST_DONE
    } state_t;

    function automatic logic [SMP_W-1:0] map_note(input logic [NOTE_W-1:0] n);
        logic [SMP_W-1:0] s;
        unique case (n)
            NOTE_KICK:       s = SMP_KICK;
            NOTE_SNARE:      s = SMP_SNARE;
            NOTE_SNARE_ALT:  s = SMP_SNARE_ALT;
            NOTE_HAT_CLOSED: s = SMP_HAT_CLOSED;
            NOTE_HAT_OPEN:   s = SMP_HAT_OPEN;
            NOTE_COWBELL:    s = SMP_COWBELL;
            NOTE_CRASH:      s = SMP_CRASH;
            default:         s = SMP_NULL;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/drum_voice_allocator_unit.sv =====
`timescale 1ns / 1ps

// Drum voice allocator: takes note-on, note-off, all-off and tick words and
// returns one command word for each. A note-on walks the channels one at a
// time through a single 16x16 multiplier, used twice per channel to
// cross-multiply playback progress, and then commits the chosen channel.
// Note-off and tick walk the channels at one a cycle. All-off and unmapped
// notes skip the walk. The input is not ready while a word is being worked
// on. A finished result waits in its own output register, so the next word
// may be taken while it is still unclaimed. A word that finishes while that
// register is still full holds the input until the register drains.
// Configuration writes are always ready.
module drum_voice_allocator_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [dva_pkg::OP_W-1:0]       op,
    input  logic [dva_pkg::NOTE_W-1:0]     note,
    input  logic [dva_pkg::VEL_W-1:0]      velocity,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [dva_pkg::ACT_W-1:0]      action,
    output logic [dva_pkg::CHAN_W-1:0]     channel,
    output logic [dva_pkg::SMP_W-1:0]      sample_index,
    output logic [dva_pkg::VEL_W-1:0]      gain,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dva_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dva_pkg::LEN_W-1:0]      cfg_data
);
    import dva_pkg::*;

    state_t               state_reg, state_next;
    logic [CH_W-1:0]      ptr_reg, ptr_next;
    logic [CH_W-1:0]      best_reg, best_next;
    logic [SMP_W-1:0]     smp_req_reg, smp_req_next;
    logic [VEL_W-1:0]     vel_reg, vel_next;
    logic [LEN_W-1:0]     bn_reg, bn_next, bd_reg, bd_next;
    logic [LEN_W-1:0]     n_reg, n_next, d_reg, d_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;

    logic [LEN_W-1:0]     length_reg [SAMPLES];
    logic [SMP_W-1:0]     smp_reg [CHANNELS];
    logic [SMP_W-1:0]     smp_next [CHANNELS];
    logic [CHANNELS-1:0]  play_reg, play_next;
    logic [LEN_W-1:0]     pos_reg [CHANNELS];
    logic [LEN_W-1:0]     pos_next [CHANNELS];

    logic [ACT_W-1:0]     res_act_reg, res_act_next;
    logic [CHAN_W-1:0]    res_chan_reg, res_chan_next;
    logic [SMP_W-1:0]     res_smp_reg, res_smp_next;
    logic [VEL_W-1:0]     res_gain_reg, res_gain_next;

    logic                 out_valid_reg, out_valid_next;
    logic [ACT_W-1:0]     out_act_reg, out_act_next;
    logic [CHAN_W-1:0]    out_chan_reg, out_chan_next;
    logic [SMP_W-1:0]     out_smp_reg, out_smp_next;
    logic [VEL_W-1:0]     out_gain_reg, out_gain_next;

    logic [SMP_W-1:0]     note_smp;
    logic [SMP_W-1:0]     cur_smp;
    logic                 cur_play;
    logic [LEN_W-1:0]     cur_pos, cur_len, inc_pos;
    logic [LEN_W-1:0]     score_n, score_d;
    logic [LEN_W-1:0]     mul_a, mul_b;
    logic [PROD_W-1:0]    mul_out;
    logic                 last_ch;
    logic                 out_free;

    assign in_ready     = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign action       = out_act_reg;
    assign channel      = out_chan_reg;
    assign sample_index = out_smp_reg;
    assign gain         = out_gain_reg;

    assign note_smp = map_note(note);
    assign cur_smp  = smp_reg[ptr_reg];
    assign cur_play = play_reg[ptr_reg];
    assign cur_pos  = pos_reg[ptr_reg];
    assign cur_len  = (cur_smp == SMP_NULL) ? '0 : length_reg[SMP_W'(cur_smp - SMP_W'(1))];
    assign inc_pos  = (cur_pos != '1) ? LEN_W'(cur_pos + LEN_W'(1)) : cur_pos;
    assign last_ch  = (ptr_reg == CH_W'(CHANNELS - 1));
    assign out_free = !out_valid_reg || out_ready;

    // progress as a fraction: exact ties and the same-sample preference kept
    always_comb
    begin
        if (cur_smp == smp_req_reg)
        begin
            score_n = LEN_W'(2);
            score_d = LEN_W'(1);
        end
        else if (!cur_play || (cur_pos >= cur_len))
        begin
            score_n = LEN_W'(1);
            score_d = LEN_W'(1);
        end
        else
        begin
            score_n = cur_pos;
            score_d = cur_len;
        end
    end

    assign mul_a   = (state_reg == ST_ON_MULA) ? n_reg  : bn_reg;
    assign mul_b   = (state_reg == ST_ON_MULA) ? bd_reg : d_reg;
    assign mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (op_t'(op))
                        OP_NOTE_ON:  state_next = (note_smp != SMP_NULL) ? ST_ON_SCORE : ST_DONE;
                        OP_NOTE_OFF: state_next = (note_smp != SMP_NULL) ? ST_OFF_SCAN : ST_DONE;
                        OP_ALL_OFF:  state_next = ST_DONE;
                        OP_TICK:     state_next = ST_TICK_SCAN;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_ON_SCORE:  state_next = ST_ON_MULA;
            ST_ON_MULA:   state_next = ST_ON_MULB;
            ST_ON_MULB:   state_next = last_ch ? ST_ON_COMMIT : ST_ON_SCORE;
            ST_ON_COMMIT: state_next = ST_DONE;
            ST_OFF_SCAN:
            begin
                if ((cur_smp == smp_req_reg) || last_ch)
                    state_next = ST_DONE;
            end
            ST_TICK_SCAN:
            begin
                if (last_ch)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ptr_next      = ptr_reg;
        best_next     = best_reg;
        smp_req_next  = smp_req_reg;
        vel_next      = vel_reg;
        bn_next       = bn_reg;
        bd_next       = bd_reg;
        n_next        = n_reg;
        d_next        = d_reg;
        prod_next     = prod_reg;
        smp_next      = smp_reg;
        play_next     = play_reg;
        pos_next      = pos_reg;
        res_act_next  = res_act_reg;
        res_chan_next = res_chan_reg;
        res_smp_next  = res_smp_reg;
        res_gain_next = res_gain_reg;
        out_act_next  = out_act_reg;
        out_chan_next = out_chan_reg;
        out_smp_next  = out_smp_reg;
        out_gain_next = out_gain_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    smp_req_next  = note_smp;
                    vel_next      = velocity;
                    ptr_next      = '0;
                    best_next     = '0;
                    // a zero score equals any other zero, so start from 0/1
                    bn_next       = '0;
                    bd_next       = LEN_W'(1);
                    res_act_next  = ACT_NONE;
                    res_chan_next = '0;
                    res_smp_next  = SMP_NULL;
                    res_gain_next = '0;
                    if (op_t'(op) == OP_ALL_OFF)
                    begin
                        play_next    = '0;
                        res_act_next = ACT_STOP_ALL;
                    end
                end
            end
            ST_ON_SCORE:
            begin
                n_next = score_n;
                d_next = score_d;
            end
            ST_ON_MULA:
            begin
                prod_next = mul_out;
            end
            ST_ON_MULB:
            begin
                if (prod_reg > mul_out)
                begin
                    best_next = ptr_reg;
                    bn_next   = n_reg;
                    bd_next   = d_reg;
                end
                ptr_next = CH_W'(ptr_reg + CH_W'(1));
            end
            ST_ON_COMMIT:
            begin
                smp_next[best_reg]  = smp_req_reg;
                play_next[best_reg] = 1'b1;
                pos_next[best_reg]  = '0;
                res_act_next        = ACT_START;
                res_chan_next       = CHAN_W'(best_reg);
                res_smp_next        = smp_req_reg;
                res_gain_next       = vel_reg;
            end
            ST_OFF_SCAN:
            begin
                if (cur_smp == smp_req_reg)
                begin
                    play_next[ptr_reg] = 1'b0;
                    pos_next[ptr_reg]  = '0;
                    res_act_next       = ACT_STOP;
                    res_chan_next      = CHAN_W'(ptr_reg);
                end
                ptr_next = CH_W'(ptr_reg + CH_W'(1));
            end
            ST_TICK_SCAN:
            begin
                if (cur_play)
                begin
                    pos_next[ptr_reg] = inc_pos;
                    if (inc_pos >= cur_len)
                        play_next[ptr_reg] = 1'b0;
                end
                ptr_next = CH_W'(ptr_reg + CH_W'(1));
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_act_next   = res_act_reg;
                    out_chan_next  = res_chan_reg;
                    out_smp_next   = res_smp_reg;
                    out_gain_next  = res_gain_reg;
                end
            end
            default:
            begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
            play_reg      <= '0;
            for (int i = 0; i < SAMPLES; i++)
                length_reg[i] <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                smp_reg[c] <= SMP_NULL;
                pos_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
            play_reg      <= play_next;
            smp_reg       <= smp_next;
            pos_reg       <= pos_next;
            if (cfg_valid && (cfg_index < CFG_IDX_W'(SAMPLES)))
                length_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        smp_req_reg  <= smp_req_next;
        vel_reg      <= vel_next;
        bn_reg       <= bn_next;
        bd_reg       <= bd_next;
        n_reg        <= n_next;
        d_reg        <= d_next;
        prod_reg     <= prod_next;
        res_act_reg  <= res_act_next;
        res_chan_reg <= res_chan_next;
        res_smp_reg  <= res_smp_next;
        res_gain_reg <= res_gain_next;
        out_act_reg  <= out_act_next;
        out_chan_reg <= out_chan_next;
        out_smp_reg  <= out_smp_next;
        out_gain_reg <= out_gain_next;
    end

endmodule

// ===== rtl/dva_checker.sv =====
`timescale 1ns / 1ps

module dva_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [dva_pkg::ACT_W-1:0]      action,
    input logic [dva_pkg::CHAN_W-1:0]     channel,
    input logic [dva_pkg::SMP_W-1:0]      sample_index,
    input logic [dva_pkg::VEL_W-1:0]      gain
);
    import dva_pkg::*;

    // hold a stalled result word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(action) && $stable(channel)
            && $stable(sample_index) && $stable(gain))
        else $error("stalled result word changed");

    // one word in flight: ready drops after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken twice in a row");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == ACT_NONE || action == ACT_STOP_ALL)
            |-> channel == '0 && sample_index == SMP_NULL && gain == '0)
        else $error("idle or stop-all word carries payload");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == ACT_START |-> sample_index != SMP_NULL)
        else $error("start word with null sample");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == ACT_STOP |-> sample_index == SMP_NULL && gain == '0)
        else $error("stop word carries sample or gain");

endmodule

bind drum_voice_allocator_unit dva_checker u_dva_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .action       (action),
    .channel      (channel),
    .sample_index (sample_index),
    .gain         (gain)
);
